[rtl/smbr_pkg.sv]
// smbr_pkg: shared types and the sequencer program for softmax_backward_row.
// No dependencies. Used by smbr_datapath and softmax_backward_row.
package smbr_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // Step addresses of the program
    localparam step_t ST_LOAD = 3'd0;
    localparam step_t ST_ACC  = 3'd1;
    localparam step_t ST_RD   = 3'd2;
    localparam step_t ST_MUL  = 3'd3;
    localparam step_t ST_OUT  = 3'd4;

    // Sequencing modes of a control word
    typedef enum logic [1:0] {
        SQ_NEXT,     // go to step + 1
        SQ_WAIT_IN,  // hold until a word is accepted, then step + 1
        SQ_CLOSE,    // row closes: step + 1, else jump to target
        SQ_EMIT      // hold while output is full; last: jump to ST_LOAD, else target
    } seq_t;

    typedef struct packed {
        logic  rdy;
        logic  acc;
        logic  rd;
        logic  mul;
        logic  emit;
        seq_t  seq;
        step_t target;
    } uword_t;

    // Datapath strobes for one cycle
    typedef struct packed {
        logic wr;
        logic acc;
        logic rd;
        logic mul;
        logic emit;
    } dp_ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic close;
        logic last;
        logic out_free;
    } dp_stat_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '{rdy: 1'b0, acc: 1'b0, rd: 1'b0, mul: 1'b0, emit: 1'b0,
              seq: SQ_NEXT, target: ST_LOAD};
        case (s)
            ST_LOAD: begin
                w.rdy = 1'b1;
                w.seq = SQ_WAIT_IN;
            end
            ST_ACC: begin
                w.acc    = 1'b1;
                w.seq    = SQ_CLOSE;
                w.target = ST_LOAD;
            end
            ST_RD: begin
                w.rd = 1'b1;
            end
            ST_MUL: begin
                w.mul = 1'b1;
            end
            ST_OUT: begin
                w.emit   = 1'b1;
                w.seq    = SQ_EMIT;
                w.target = ST_RD;
            end
            default: begin
                w.seq    = SQ_CLOSE;
                w.target = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

[rtl/smbr_datapath.sv]
// smbr_datapath: row store, dot-product accumulator, gradient multiplier and
// output register. Driven step by step from the sequencer. Uses smbr_pkg.
module smbr_datapath #(
    parameter int ROW_MAX = 64
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  smbr_pkg::dp_ctrl_t     ctrl,
    output smbr_pkg::dp_stat_t     stat,
    input  logic [15:0]            s_prob,
    input  logic signed [15:0]     s_grad,
    input  logic                   s_row_end,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [15:0]     m_grad_in,
    output logic                   m_last_out,
    output logic                   m_clipped,
    output logic                   m_row_cut
);

    localparam int AW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int CW = $clog2(ROW_MAX + 1);

    logic [31:0] mem [ROW_MAX];

    logic [CW-1:0]        fill_reg, fill_next;
    logic [AW-1:0]        k_reg, k_next;
    logic signed [23:0]   dot_reg, dot_next;
    logic                 cut_reg, cut_next;
    logic                 m_valid_reg, m_valid_next;

    logic signed [32:0]   prod_reg;
    logic                 end_reg;
    logic [31:0]          rd_reg;
    logic signed [41:0]   mul_reg;

    logic signed [15:0]   grad_in_reg;
    logic                 last_reg, clip_reg, rcut_reg;

    logic signed [32:0]   prod_rnd;
    logic signed [24:0]   diff;
    logic signed [41:0]   res_rnd;
    logic                 sat_hi, sat_lo;
    logic                 is_last;

    // status depends on registers and m_ready only, never on the strobes
    always_comb begin
        is_last       = (CW'(k_reg) + CW'(1)) == fill_reg;
        stat.close    = end_reg || (fill_reg == CW'(ROW_MAX));
        stat.last     = is_last;
        stat.out_free = !m_valid_reg || m_ready;
    end

    always_comb begin
        prod_rnd = (prod_reg + 33'sd16384) >>> 15;
        diff     = 25'(signed'(rd_reg[15:0])) - 25'(dot_reg);
        res_rnd  = (mul_reg + 42'sd16384) >>> 15;
        sat_hi   = res_rnd > 42'sd32767;
        sat_lo   = res_rnd < -42'sd32768;

        fill_next    = fill_reg;
        k_next       = k_reg;
        dot_next     = dot_reg;
        cut_next     = cut_reg;
        m_valid_next = m_valid_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctrl.wr) begin
            fill_next = fill_reg + CW'(1);
        end
        if (ctrl.acc) begin
            dot_next = dot_reg + prod_rnd[23:0];
            cut_next = !end_reg;
            k_next   = '0;
        end
        if (ctrl.emit) begin
            m_valid_next = 1'b1;
            if (is_last) begin
                fill_next = '0;
                dot_next  = '0;
                k_next    = '0;
            end else begin
                k_next = k_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            k_reg       <= '0;
            dot_reg     <= '0;
            cut_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            k_reg       <= k_next;
            dot_reg     <= dot_next;
            cut_reg     <= cut_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Row store: one write port on accept, one registered read port
    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            mem[fill_reg[AW-1:0]] <= {s_prob, s_grad};
        end
        if (ctrl.rd) begin
            rd_reg <= mem[k_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            prod_reg <= signed'({1'b0, s_prob}) * s_grad;
            end_reg  <= s_row_end;
        end
        if (ctrl.mul) begin
            mul_reg <= signed'({1'b0, rd_reg[31:16]}) * diff;
        end
        if (ctrl.emit) begin
            if (sat_hi) begin
                grad_in_reg <= 16'sh7FFF;
            end else if (sat_lo) begin
                grad_in_reg <= -16'sh8000;
            end else begin
                grad_in_reg <= res_rnd[15:0];
            end
            clip_reg <= sat_hi || sat_lo;
            last_reg <= is_last;
            rcut_reg <= cut_reg;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_grad_in  = grad_in_reg;
    assign m_last_out = last_reg;
    assign m_clipped  = clip_reg;
    assign m_row_cut  = rcut_reg;

endmodule

[rtl/softmax_backward_row.sv]
// softmax_backward_row: softmax gradient over one row, microcoded control.
// Depends on smbr_pkg and smbr_datapath.
//
// Input channel (s_valid/s_ready): one word per element, carrying the saved
// probability s_prob (unsigned Q1.15), the upstream gradient s_grad (signed
// Q4.12) and s_row_end on the row's final element.
// Output channel (m_valid/m_ready): one word per stored element, emitted in
// arrival order once the row closes: m_grad_in = prob*(grad - dot), rounded
// and saturated (m_clipped), m_last_out on the final word, m_row_cut on every
// word of a row that closed at ROW_MAX elements without s_row_end.
// Sequence: each element is loaded by a store + multiply step, then an accumulate
// step. After the row closes, each result passes through a memory read, a
// multiply and a round/saturate into the output register. s_ready is low
// while the row is being emitted.
// A stalled receiver holds the output register; the sequencer waits at its
// output step until the register frees. After the final result is loaded,
// the next row's input is taken while that result still waits.
// Reset (aresetn low, synchronous) empties the row and the output register.
module softmax_backward_row #(
    parameter int ROW_MAX = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_prob,
    input  logic signed [15:0] s_grad,
    input  logic               s_row_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_grad_in,
    output logic               m_last_out,
    output logic               m_clipped,
    output logic               m_row_cut
);

    smbr_pkg::step_t    step_reg, step_next;
    smbr_pkg::uword_t   uw;
    smbr_pkg::dp_ctrl_t ctrl;
    smbr_pkg::dp_stat_t stat;
    logic               accept;

    always_comb begin
        uw        = smbr_pkg::ucode(step_reg);
        accept    = s_valid && uw.rdy;
        ctrl.wr   = accept;
        ctrl.acc  = uw.acc;
        ctrl.rd   = uw.rd;
        ctrl.mul  = uw.mul;
        ctrl.emit = uw.emit && stat.out_free;

        step_next = step_reg;
        unique case (uw.seq)
            smbr_pkg::SQ_NEXT: begin
                step_next = step_reg + smbr_pkg::step_t'(1);
            end
            smbr_pkg::SQ_WAIT_IN: begin
                if (accept) begin
                    step_next = step_reg + smbr_pkg::step_t'(1);
                end
            end
            smbr_pkg::SQ_CLOSE: begin
                step_next = stat.close ? step_reg + smbr_pkg::step_t'(1) : uw.target;
            end
            smbr_pkg::SQ_EMIT: begin
                if (stat.out_free) begin
                    step_next = stat.last ? smbr_pkg::ST_LOAD : uw.target;
                end
            end
            default: begin
                step_next = smbr_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= smbr_pkg::ST_LOAD;
        end else begin
            step_reg <= step_next;
        end
    end

    assign s_ready = uw.rdy;

    smbr_datapath #(
        .ROW_MAX (ROW_MAX)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .stat       (stat),
        .s_prob     (s_prob),
        .s_grad     (s_grad),
        .s_row_end  (s_row_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_grad_in  (m_grad_in),
        .m_last_out (m_last_out),
        .m_clipped  (m_clipped),
        .m_row_cut  (m_row_cut)
    );

endmodule

[sim/softmax_backward_row_checker.sv]
// softmax_backward_row_checker: watches both channels of softmax_backward_row,
// predicts the gradient words of each row and compares them as they leave.
// Self-contained; instantiated beside the block by tb_softmax_backward_row.
module softmax_backward_row_checker #(
    parameter int ROW_MAX = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_prob,
    input  logic signed [15:0] s_grad,
    input  logic               s_row_end,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_grad_in,
    input  logic               m_last_out,
    input  logic               m_clipped,
    input  logic               m_row_cut,
    output int                 mismatches,
    output int                 outstanding
);

    typedef struct packed {
        logic signed [15:0] grad_in;
        logic               last;
        logic               clipped;
        logic               cut;
    } grad_word_t;

    logic [15:0]        row_probs [ROW_MAX];
    logic signed [15:0] row_grads [ROW_MAX];
    longint             dot_sum;
    int                 held;
    grad_word_t         expected_grads [$];

    // floor((x + 2^14) / 2^15): Q.27 product back to Q.12, round half up
    function automatic longint round_to_q12(longint x);
        return (x + 64'sd16384) >>> 15;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic take_element(logic [15:0] p, logic signed [15:0] g, logic row_end);
        longint     diff;
        longint     r;
        grad_word_t w;
        row_probs[held] = p;
        row_grads[held] = g;
        dot_sum += round_to_q12(longint'(p) * longint'(g));
        held++;
        if (row_end || held == ROW_MAX) begin
            for (int k = 0; k < held; k++) begin
                diff = longint'(row_grads[k]) - dot_sum;
                r = round_to_q12(longint'(row_probs[k]) * diff);
                w.clipped = 1'b0;
                if (r > 32767) begin
                    r = 32767;
                    w.clipped = 1'b1;
                end else if (r < -32768) begin
                    r = -32768;
                    w.clipped = 1'b1;
                end
                w.grad_in = r[15:0];
                w.last    = (k == held - 1);
                w.cut     = !row_end;
                expected_grads.push_back(w);
            end
            dot_sum = 0;
            held    = 0;
        end
    endtask

    task automatic check_word();
        grad_word_t w;
        if (expected_grads.size() == 0) begin
            report_mismatch("gradient word with none pending", int'(m_grad_in), 0);
        end else begin
            w = expected_grads.pop_front();
            if (m_grad_in !== w.grad_in)
                report_mismatch("grad_in", int'(m_grad_in), int'(w.grad_in));
            if (m_last_out !== w.last)
                report_mismatch("last_out", int'(m_last_out), int'(w.last));
            if (m_clipped !== w.clipped)
                report_mismatch("clipped", int'(m_clipped), int'(w.clipped));
            if (m_row_cut !== w.cut)
                report_mismatch("row_cut", int'(m_row_cut), int'(w.cut));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            held    = 0;
            dot_sum = 0;
            expected_grads.delete();
            mismatches = 0;
        end else begin
            // push before pop: a row closing on this edge queues behind older words
            if (s_valid && s_ready)
                take_element(s_prob, s_grad, s_row_end);
            if (m_valid && m_ready)
                check_word();
        end
        outstanding <= expected_grads.size();
    end

endmodule

[sim/tb_softmax_backward_row.sv]
// tb_softmax_backward_row: drives rows of probability/gradient words into
// softmax_backward_row with bursty input and a stalling receiver.
// Depends on softmax_backward_row and softmax_backward_row_checker.
module tb_softmax_backward_row;

    localparam int ROW_MAX     = 64;
    localparam int RANDOM_WORDS = 360;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [15:0]        s_prob    = '0;
    logic signed [15:0] s_grad    = '0;
    logic               s_row_end = 1'b0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [15:0] m_grad_in;
    logic               m_last_out;
    logic               m_clipped;
    logic               m_row_cut;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int burst_left  = 0;
    int words_sent  = 0;
    int stall_mode  = 0;
    int stall_phase = 0;

    softmax_backward_row #(.ROW_MAX(ROW_MAX)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_prob     (s_prob),
        .s_grad     (s_grad),
        .s_row_end  (s_row_end),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_grad_in  (m_grad_in),
        .m_last_out (m_last_out),
        .m_clipped  (m_clipped),
        .m_row_cut  (m_row_cut)
    );

    softmax_backward_row_checker #(.ROW_MAX(ROW_MAX)) u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_prob      (s_prob),
        .s_grad      (s_grad),
        .s_row_end   (s_row_end),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_grad_in   (m_grad_in),
        .m_last_out  (m_last_out),
        .m_clipped   (m_clipped),
        .m_row_cut   (m_row_cut),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("softmax_backward_row: mismatch");
            $finish;
        end
    end

    // receiver: stall style changes whenever stall_phase wraps
    always @(posedge aclk) begin
        if (stall_phase == 47) begin
            stall_phase <= 0;
            stall_mode  <= $urandom_range(0, 3);
        end else begin
            stall_phase <= stall_phase + 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (stall_phase % 5 != 0);
        endcase
    end

    function automatic logic [15:0] pick_prob();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_grad();
        case ($urandom_range(0, 9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2, 3: return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom());
        endcase
    endfunction

    // one word; valid stays up between words of a burst
    task automatic send_word(logic [15:0] p, logic signed [15:0] g, logic row_end);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        s_valid   <= 1'b1;
        s_prob    <= p;
        s_grad    <= g;
        s_row_end <= row_end;
        // ready is stable between edges, so look at it on the falling edge
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
        burst_left--;
        words_sent++;
    endtask

    task automatic send_row(int len, bit cut);
        for (int i = 0; i < len; i++)
            send_word(pick_prob(), pick_grad(), !cut && (i == len - 1));
    endtask

    initial begin
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single-word rows at the field extremes, prob above 1.0 included
        send_word(16'd0, -16'sd32768, 1'b1);
        send_word(16'd32768, 16'sd32767, 1'b1);
        send_word(16'hFFFF, -16'sd32768, 1'b1);
        // dot near zero, large diffs: saturates high, then low
        send_word(16'hFFFF, 16'sd32767, 1'b0);
        send_word(16'hFFFF, -16'sd32768, 1'b1);
        send_word(16'd1, 16'sd1, 1'b0);
        send_word(16'h8000, 16'sh7FFF, 1'b0);
        send_word(16'hFFFF, -16'sd1, 1'b1);
        send_word(16'hAAAA, 16'sh5555, 1'b0);
        send_word(16'h5555, 16'shAAAA, 1'b0);
        send_word(16'h7FFF, 16'sd0, 1'b0);
        send_word(16'h0001, -16'sd32768, 1'b1);

        // full row cut at ROW_MAX, then full row that ends exactly at ROW_MAX
        words_sent = 0;
        send_row(ROW_MAX, 1'b1);
        send_row(ROW_MAX, 1'b0);
        while (words_sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 7) == 0) begin
                send_row(ROW_MAX, 1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(1, 12);
                send_row(len, 1'b0);
            end
        end
        s_valid <= 1'b0;

        do @(negedge aclk); while (outstanding != 0);
        repeat (32) @(posedge aclk);
        if (mismatches == 0)
            $display("softmax_backward_row: match");
        else
            $display("softmax_backward_row: mismatch");
        $finish;
    end

endmodule
